// File: sv/acfm_pkg.sv
`timescale 1ns / 1ps
package acfm_pkg;
  localparam int unsigned CHANNELS_DEF = 3;
  localparam int unsigned MAX_CH = 3;

  localparam logic [31:0] TICK_INTERVAL_MS = 32'd10;
  localparam logic [31:0] RAIL_HEAL_MS     = 32'd2000;
  localparam logic [31:0] STUCK_HEAL_MS    = 32'd2000;
  localparam logic [7:0]  STUCK_MIN_CHANGES = 8'd10;
  localparam logic [31:0] STUCK_GAP_MS     = 32'd200;
  localparam logic [6:0]  BIAS_WINDOW      = 7'd100;
  localparam logic [31:0] BIAS_HEAL_MS     = 32'd5000;
  localparam logic [31:0] DMA_STALL_MS     = 32'd1000;
  localparam logic [31:0] DMA_HEAL_MS      = 32'd2000;
  localparam logic [7:0]  CHANGE_SAT       = 8'hFF;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_LOW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_HIGH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_LOW    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_HIGH   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RAIL_CONF   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STUCK_CONF  = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_CONF   = 8'd7;

  typedef struct packed {
    logic [11:0] rail_low;
    logic [11:0] rail_high;
    logic [11:0] bias_low;
    logic [11:0] bias_high;
    logic [7:0]  deadband;
    logic [31:0] rail_conf;
    logic [31:0] stuck_conf;
    logic [31:0] bias_conf;
  } cfg_t;

  // one tick as seen by every lane
  typedef struct packed {
    logic        valid;
    logic [31:0] now;
    logic        fire;
    logic        first;
  } lane_ctl_t;

  typedef struct packed {
    logic rail;
    logic stuck;
    logic bias;
  } lane_stat_t;
endpackage

// File: sv/acfm_lane.sv
`timescale 1ns / 1ps
module acfm_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  acfm_pkg::cfg_t     cfg_i,
  input  acfm_pkg::lane_ctl_t ctl_i,
  input  logic               ok_i,
  input  logic [11:0]        raw_i,
  output acfm_pkg::lane_stat_t stat_o
);
  logic [31:0] rail_start_q, rail_start_d, rail_rec_q, rail_rec_d;
  logic        rail_tim_q, rail_tim_d, rail_flt_q, rail_flt_d;
  logic [11:0] base_q, base_d;
  logic [31:0] chg_q, chg_d, srec_q, srec_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        sflt_q, sflt_d;
  logic [18:0] bsum_q, bsum_d;
  logic [6:0]  bcnt_q, bcnt_d;
  logic [31:0] bstart_q, bstart_d, brec_q, brec_d;
  logic        btim_q, btim_d, bflt_q, bflt_d;

  logic [31:0] now;
  logic [11:0] base;
  logic [31:0] chg;
  logic [11:0] delta;
  logic [18:0] sum_new;
  logic [11:0] mean;
  logic [7:0]  cnt_inc;
  logic [38:0] mean_prod;

  assign now = ctl_i.now;
  assign base = ctl_i.first ? raw_i : base_q;
  assign chg  = ctl_i.first ? now : chg_q;
  assign delta = (raw_i >= base) ? raw_i - base : base - raw_i;
  assign sum_new = bsum_q + 19'(raw_i);
  // divide by 100: multiply by ceil(2^26/100); exact for sums below 1864135
  assign mean_prod = 39'(sum_new) * 39'(20'd671089);
  assign mean = 12'(mean_prod >> 26);

  always_comb begin
    rail_start_d = rail_start_q; rail_rec_d = rail_rec_q;
    rail_tim_d = rail_tim_q; rail_flt_d = rail_flt_q;
    base_d = base_q; chg_d = chg_q; srec_d = srec_q; cnt_d = cnt_q; sflt_d = sflt_q;
    bsum_d = bsum_q; bcnt_d = bcnt_q; bstart_d = bstart_q; brec_d = brec_q;
    btim_d = btim_q; bflt_d = bflt_q;
    cnt_inc = cnt_q;
    if (ctl_i.valid && ok_i) begin
      base_d = base; chg_d = chg;
      if (raw_i <= cfg_i.rail_low || raw_i >= cfg_i.rail_high) begin
        rail_rec_d = '0;
        if (!rail_tim_q) begin
          rail_tim_d = 1'b1; rail_start_d = now;
        end else if (now - rail_start_q >= cfg_i.rail_conf) begin
          rail_flt_d = 1'b1;
        end
      end else begin
        rail_tim_d = 1'b0; rail_start_d = '0;
        if (!rail_flt_q) rail_rec_d = '0;
        else if (rail_rec_q == '0) rail_rec_d = now;
        else if (now - rail_rec_q >= acfm_pkg::RAIL_HEAL_MS) begin
          rail_flt_d = 1'b0; rail_rec_d = '0;
        end
      end
      if (delta > 12'(cfg_i.deadband)) begin
        base_d = raw_i; chg_d = now;
        if (sflt_q) begin
          if (srec_q == '0) begin
            srec_d = now; cnt_inc = 8'd1;
          end else if (cnt_q < acfm_pkg::CHANGE_SAT) begin
            cnt_inc = cnt_q + 8'd1;
          end
          cnt_d = cnt_inc;
          if (now - srec_d >= acfm_pkg::STUCK_HEAL_MS &&
              cnt_inc >= acfm_pkg::STUCK_MIN_CHANGES) begin
            sflt_d = 1'b0; srec_d = '0; cnt_d = '0;
          end
        end
      end else if (!sflt_q) begin
        if (now - chg >= cfg_i.stuck_conf) sflt_d = 1'b1;
      end else if (srec_q != '0 && now - chg >= acfm_pkg::STUCK_GAP_MS) begin
        srec_d = '0; cnt_d = '0;
      end
      if (!ctl_i.fire) begin
        if (bcnt_q + 7'd1 >= acfm_pkg::BIAS_WINDOW) begin
          bsum_d = '0; bcnt_d = '0;
          if (mean < cfg_i.bias_low || mean > cfg_i.bias_high) begin
            brec_d = '0;
            if (!btim_q) begin
              btim_d = 1'b1; bstart_d = now;
            end else if (now - bstart_q >= cfg_i.bias_conf) begin
              bflt_d = 1'b1;
            end
          end else begin
            btim_d = 1'b0; bstart_d = '0;
            if (!bflt_q) brec_d = '0;
            else if (brec_q == '0) brec_d = now;
            else if (now - brec_q >= acfm_pkg::BIAS_HEAL_MS) begin
              bflt_d = 1'b0; brec_d = '0;
            end
          end
        end else begin
          bsum_d = sum_new; bcnt_d = bcnt_q + 7'd1;
        end
      end
    end
    if (ctl_i.valid && ctl_i.fire) begin
      bsum_d = '0; bcnt_d = '0; bstart_d = '0; brec_d = '0; btim_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rail_start_q <= '0; rail_rec_q <= '0; rail_tim_q <= 1'b0; rail_flt_q <= 1'b0;
      base_q <= '0; chg_q <= '0; srec_q <= '0; cnt_q <= '0; sflt_q <= 1'b0;
      bsum_q <= '0; bcnt_q <= '0; bstart_q <= '0; brec_q <= '0;
      btim_q <= 1'b0; bflt_q <= 1'b0;
    end else begin
      rail_start_q <= rail_start_d; rail_rec_q <= rail_rec_d;
      rail_tim_q <= rail_tim_d; rail_flt_q <= rail_flt_d;
      base_q <= base_d; chg_q <= chg_d; srec_q <= srec_d; cnt_q <= cnt_d;
      sflt_q <= sflt_d; bsum_q <= bsum_d; bcnt_q <= bcnt_d;
      bstart_q <= bstart_d; brec_q <= brec_d; btim_q <= btim_d; bflt_q <= bflt_d;
    end
  end

  assign stat_o.rail  = rail_flt_d;
  assign stat_o.stuck = sflt_d;
  assign stat_o.bias  = bflt_d;
endmodule

// File: sv/acfm_dma.sv
`timescale 1ns / 1ps
module acfm_dma (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        eval_i,
  input  logic [31:0] now_i,
  input  logic        running_i,
  input  logic [31:0] upd_i,
  input  logic [31:0] err_i,
  input  logic        read_fail_i,
  output logic        fault_o
);
  logic [31:0] upd_q, upd_d, err_q, err_d, prog_q, prog_d, rec_q, rec_d;
  logic        recv_q, recv_d, flt_q, flt_d;
  logic        progressed;

  assign progressed = upd_i != upd_q;

  always_comb begin
    upd_d = upd_q; err_d = err_q; prog_d = prog_q; rec_d = rec_q;
    recv_d = recv_q; flt_d = flt_q;
    if (eval_i) begin
      upd_d = upd_i; err_d = err_i;
      if (progressed) prog_d = now_i;
      if (!running_i || err_i != err_q || now_i - prog_d >= acfm_pkg::DMA_STALL_MS) begin
        flt_d = 1'b1; recv_d = 1'b0; rec_d = '0;
      end else if (flt_q && progressed) begin
        if (!recv_q) begin
          recv_d = 1'b1; rec_d = now_i;
        end else if (now_i - rec_q >= acfm_pkg::DMA_HEAL_MS) begin
          flt_d = 1'b0; recv_d = 1'b0; rec_d = '0;
        end
      end
      if (read_fail_i) flt_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q <= '0; err_q <= '0; prog_q <= '0; rec_q <= '0; recv_q <= 1'b0; flt_q <= 1'b0;
    end else begin
      upd_q <= upd_d; err_q <= err_d; prog_q <= prog_d; rec_q <= rec_d;
      recv_q <= recv_d; flt_q <= flt_d;
    end
  end

  assign fault_o = flt_d;
endmodule

// File: sv/adc_chain_fault_monitor.sv
`timescale 1ns / 1ps
// The result beat of an accepted input beat is registered at the accepting edge.
// Throughput: one tick per cycle while results are taken; all lanes and the transfer check
// finish a tick in its accepting cycle; an untaken waiting result holds off the next beat.
// Reset (rst_ni low, asynchronous) clears all timers, windows and flags to zero and
// loads the register defaults.
module adc_chain_fault_monitor #(
  parameter int unsigned CHANNELS = acfm_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // now_ms[31:0], fire[32], dma_running[33], dma_update_count[65:34],
  // dma_error_count[97:66], read_ok_mask[100:98], raw_ch0[112:101],
  // raw_ch1[124:113], raw_ch2[136:125], zero fill to 144
  input  logic [143:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // any_fault[0], rail mask[3:1], flag bits[6:4], tick_taken[7]
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  acfm_pkg::cfg_t cfg_q;
  logic [31:0] last_q;
  logic        first_q;
  logic [2:0]  flags_q;
  logic        ovalid_q;
  logic [7:0]  odata_q;

  logic        in_acc;
  logic [31:0] now;
  logic        eval;
  logic [2:0]  okm;
  logic [2:0]  okm_used;
  acfm_pkg::lane_ctl_t ctl;
  acfm_pkg::lane_stat_t stat [CHANNELS];
  logic        dma_flt;
  logic [2:0]  flags_d, railm_d;
  logic [CHANNELS-1:0] rail_v, stuck_v, bias_v;

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign now = s_axis_tdata[31:0];
  assign okm = s_axis_tdata[100:98];
  assign eval = in_acc && (now - last_q >= acfm_pkg::TICK_INTERVAL_MS);

  assign ctl.valid = eval;
  assign ctl.now = now;
  assign ctl.fire = s_axis_tdata[32];
  assign ctl.first = !first_q;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    acfm_lane u_lane (
      .clk_i, .rst_ni, .cfg_i(cfg_q), .ctl_i(ctl), .ok_i(okm[c]),
      .raw_i(s_axis_tdata[101 + 12*c +: 12]), .stat_o(stat[c])
    );
    assign rail_v[c] = stat[c].rail;
    assign stuck_v[c] = stat[c].stuck;
    assign bias_v[c] = stat[c].bias;
  end

  always_comb begin
    okm_used = 3'b111;
    for (int c = 0; c < CHANNELS; c++) okm_used[c] = okm[c];
  end

  acfm_dma u_dma (
    .clk_i, .rst_ni, .eval_i(eval), .now_i(now), .running_i(s_axis_tdata[33]),
    .upd_i(s_axis_tdata[65:34]), .err_i(s_axis_tdata[97:66]),
    .read_fail_i(okm_used != 3'b111), .fault_o(dma_flt)
  );

  // merge lanes
  always_comb begin
    railm_d = '0;
    railm_d[CHANNELS-1:0] = rail_v;
    flags_d = eval ? {dma_flt, |bias_v, |stuck_v} : flags_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{rail_low: 12'd16, rail_high: 12'd4079, bias_low: 12'd1024,
                 bias_high: 12'd3071, deadband: 8'd5, rail_conf: 32'd20000,
                 stuck_conf: 32'd600000, bias_conf: 32'd60000};
      last_q <= '0; first_q <= 1'b0; flags_q <= '0;
      ovalid_q <= 1'b0; odata_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          acfm_pkg::REG_RAIL_LOW:   cfg_q.rail_low <= cfg_data_i[11:0];
          acfm_pkg::REG_RAIL_HIGH:  cfg_q.rail_high <= cfg_data_i[11:0];
          acfm_pkg::REG_BIAS_LOW:   cfg_q.bias_low <= cfg_data_i[11:0];
          acfm_pkg::REG_BIAS_HIGH:  cfg_q.bias_high <= cfg_data_i[11:0];
          acfm_pkg::REG_DEADBAND:   cfg_q.deadband <= cfg_data_i[7:0];
          acfm_pkg::REG_RAIL_CONF:  cfg_q.rail_conf <= cfg_data_i;
          acfm_pkg::REG_STUCK_CONF: cfg_q.stuck_conf <= cfg_data_i;
          acfm_pkg::REG_BIAS_CONF:  cfg_q.bias_conf <= cfg_data_i;
          default: ;
        endcase
      end
      if (eval) begin
        last_q <= now; first_q <= 1'b1;
      end
      flags_q <= flags_d;
      if (in_acc) begin
        ovalid_q <= 1'b1;
        odata_q <= {eval, flags_d, railm_d, (railm_d != '0) || (flags_d != '0)};
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;
endmodule

// File: sv/acfm_checker.sv
`timescale 1ns / 1ps
module acfm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);
  a_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[6:1] != 6'd0))
    else $error("any_fault mismatch");
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("missing result");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("stalled while empty");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule

bind adc_chain_fault_monitor acfm_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

// File: bench/adc_chain_fault_monitor_test.sv
`timescale 1ns / 1ps
module adc_chain_fault_monitor_test;
  typedef struct packed {
    logic [2:0]  flag_set;
    logic [2:0]  rail_mask;
    logic        any_fault;
    logic        taken;
  } status_t;

  typedef struct {
    logic [31:0] now;
    logic        fire;
    logic        running;
    logic [31:0] upd;
    logic [31:0] err;
    logic [2:0]  ok;
    logic [11:0] raw [3];
  } tick_t;

  // Behavioral copy of the monitor; predicts one status beat per tick.
  class fault_scoreboard;
    logic [11:0] rail_lo, rail_hi, bias_lo, bias_hi;
    logic [7:0]  deadband;
    logic [31:0] rail_conf, stuck_conf, bias_conf;
    logic [31:0] last_tick;
    logic [31:0] r_start [3], r_rec [3], s_chg [3], s_rec [3], b_start [3], b_rec [3];
    logic        r_timing [3], r_fault [3], s_fault [3], b_timing [3], b_fault [3];
    logic [11:0] s_base [3];
    logic [7:0]  s_count [3];
    logic [18:0] b_sum [3];
    logic [6:0]  b_count [3];
    logic        seen, d_recovering, d_fault;
    logic [31:0] prev_upd, prev_err, d_prog, d_rec;
    logic [2:0]  flags;
    status_t     pending [$];
    int          errors;

    function new();
      errors = 0;
      rail_lo = 12'd16; rail_hi = 12'd4079; bias_lo = 12'd1024; bias_hi = 12'd3071;
      deadband = 8'd5; rail_conf = 32'd20000; stuck_conf = 32'd600000;
      bias_conf = 32'd60000;
      last_tick = '0; seen = 0; d_recovering = 0; d_fault = 0;
      prev_upd = '0; prev_err = '0; d_prog = '0; d_rec = '0; flags = '0;
      for (int c = 0; c < 3; c++) begin
        r_start[c] = '0; r_rec[c] = '0; s_chg[c] = '0; s_rec[c] = '0;
        b_start[c] = '0; b_rec[c] = '0; r_timing[c] = 0; r_fault[c] = 0;
        s_fault[c] = 0; b_timing[c] = 0; b_fault[c] = 0; s_base[c] = '0;
        s_count[c] = '0; b_sum[c] = '0; b_count[c] = '0;
      end
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] v);
      case (idx)
        acfm_pkg::REG_RAIL_LOW:   rail_lo = v[11:0];
        acfm_pkg::REG_RAIL_HIGH:  rail_hi = v[11:0];
        acfm_pkg::REG_BIAS_LOW:   bias_lo = v[11:0];
        acfm_pkg::REG_BIAS_HIGH:  bias_hi = v[11:0];
        acfm_pkg::REG_DEADBAND:   deadband = v[7:0];
        acfm_pkg::REG_RAIL_CONF:  rail_conf = v;
        acfm_pkg::REG_STUCK_CONF: stuck_conf = v;
        acfm_pkg::REG_BIAS_CONF:  bias_conf = v;
        default: ;
      endcase
    endfunction

    function void rail_check(int c, logic [11:0] x, logic [31:0] now);
      if (x <= rail_lo || x >= rail_hi) begin
        r_rec[c] = '0;
        if (!r_timing[c]) begin
          r_timing[c] = 1; r_start[c] = now;
        end else if (now - r_start[c] >= rail_conf) r_fault[c] = 1;
      end else begin
        r_timing[c] = 0; r_start[c] = '0;
        if (!r_fault[c]) r_rec[c] = '0;
        else if (r_rec[c] == 0) r_rec[c] = now;
        else if (now - r_rec[c] >= acfm_pkg::RAIL_HEAL_MS) begin
          r_fault[c] = 0; r_rec[c] = '0;
        end
      end
    endfunction

    function void stuck_check(int c, logic [11:0] x, logic [31:0] now);
      logic [11:0] delta;
      delta = (x >= s_base[c]) ? x - s_base[c] : s_base[c] - x;
      if (delta > deadband) begin
        s_base[c] = x; s_chg[c] = now;
        if (s_fault[c]) begin
          if (s_rec[c] == 0) begin
            s_rec[c] = now; s_count[c] = 8'd1;
          end else if (s_count[c] < acfm_pkg::CHANGE_SAT) s_count[c]++;
          if (now - s_rec[c] >= acfm_pkg::STUCK_HEAL_MS &&
              s_count[c] >= acfm_pkg::STUCK_MIN_CHANGES) begin
            s_fault[c] = 0; s_rec[c] = '0; s_count[c] = '0;
          end
        end
      end else if (!s_fault[c]) begin
        if (now - s_chg[c] >= stuck_conf) s_fault[c] = 1;
      end else if (s_rec[c] != 0 && now - s_chg[c] >= acfm_pkg::STUCK_GAP_MS) begin
        s_rec[c] = '0; s_count[c] = '0;
      end
    endfunction

    function void bias_accumulate(int c, logic [11:0] x, logic [31:0] now);
      logic [18:0] mean;
      b_sum[c] += 19'(x);
      b_count[c]++;
      if (b_count[c] < acfm_pkg::BIAS_WINDOW) return;
      mean = b_sum[c] / 19'd100;
      b_sum[c] = '0; b_count[c] = '0;
      if (mean < bias_lo || mean > bias_hi) begin
        b_rec[c] = '0;
        if (!b_timing[c]) begin
          b_timing[c] = 1; b_start[c] = now;
        end else if (now - b_start[c] >= bias_conf) b_fault[c] = 1;
      end else begin
        b_timing[c] = 0; b_start[c] = '0;
        if (!b_fault[c]) b_rec[c] = '0;
        else if (b_rec[c] == 0) b_rec[c] = now;
        else if (now - b_rec[c] >= acfm_pkg::BIAS_HEAL_MS) begin
          b_fault[c] = 0; b_rec[c] = '0;
        end
      end
    endfunction

    function void transfer_check(tick_t t);
      logic progressed, new_err;
      progressed = t.upd != prev_upd;
      new_err = t.err != prev_err;
      prev_upd = t.upd; prev_err = t.err;
      if (progressed) d_prog = t.now;
      if (!t.running || new_err || t.now - d_prog >= acfm_pkg::DMA_STALL_MS) begin
        d_fault = 1; d_recovering = 0; d_rec = '0;
      end else if (d_fault && progressed) begin
        if (!d_recovering) begin
          d_recovering = 1; d_rec = t.now;
        end else if (t.now - d_rec >= acfm_pkg::DMA_HEAL_MS) begin
          d_fault = 0; d_recovering = 0; d_rec = '0;
        end
      end
    endfunction

    function void note_tick(tick_t t);
      status_t s;
      logic all_ok;
      s = '0;
      if (t.now - last_tick >= acfm_pkg::TICK_INTERVAL_MS) begin
        s.taken = 1; all_ok = 1; last_tick = t.now;
        transfer_check(t);
        for (int c = 0; c < 3; c++) begin
          if (!t.ok[c]) begin
            all_ok = 0;
            continue;
          end
          if (!seen) begin
            s_base[c] = t.raw[c]; s_chg[c] = t.now;
          end
          rail_check(c, t.raw[c], t.now);
          stuck_check(c, t.raw[c], t.now);
          if (!t.fire) bias_accumulate(c, t.raw[c], t.now);
        end
        seen = 1;
        if (t.fire)
          for (int c = 0; c < 3; c++) begin
            b_sum[c] = '0; b_count[c] = '0; b_start[c] = '0; b_rec[c] = '0;
            b_timing[c] = 0;
          end
        if (!all_ok) d_fault = 1;
        flags = '0;
        for (int c = 0; c < 3; c++) begin
          if (s_fault[c]) flags[0] = 1;
          if (b_fault[c]) flags[1] = 1;
        end
        if (d_fault) flags[2] = 1;
      end
      for (int c = 0; c < 3; c++) s.rail_mask[c] = r_fault[c];
      s.flag_set = flags;
      s.any_fault = (s.rail_mask != 0) || (flags != 0);
      pending.push_back(s);
    endfunction

    function void check_status(logic [7:0] beat);
      status_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected status beat %h", $time, beat);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (beat[0] !== e.any_fault || beat[3:1] !== e.rail_mask ||
          beat[6:4] !== e.flag_set || beat[7] !== e.taken) begin
        $display("%0t: status mismatch expected any=%b rail=%b flags=%b taken=%b, got %h",
                 $time, e.any_fault, e.rail_mask, e.flag_set, e.taken, beat);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 0;
  logic          rst_ni = 0;
  logic          s_axis_tvalid = 0;
  logic          s_axis_tready;
  logic [143:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 0;
  logic [7:0]    m_axis_tdata;
  logic          cfg_valid_i = 0;
  logic          cfg_ready_o;
  logic [7:0]    cfg_index_i = '0;
  logic [31:0]   cfg_data_i = '0;

  fault_scoreboard monitor_model = new();
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;
  logic [31:0] clock_ms, upd_count, err_count;

  adc_chain_fault_monitor dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (m_axis_tvalid && m_axis_tready) monitor_model.check_status(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("adc_chain_fault_monitor regression: fail");
      $finish;
    end
  end

  // valid stays high after the accepting edge until the next beat or an idle gap
  task automatic send_tick(tick_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {7'b0, t.raw[2], t.raw[1], t.raw[0], t.ok, t.err, t.upd,
                     t.running, t.fire, t.now};
    do @(posedge clk_i); while (!s_axis_tready);
    monitor_model.note_tick(t);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] v);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    monitor_model.write_reg(idx, v);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (monitor_model.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly healthy ticks stepping time forward; sometimes jumps, noise and faults.
  task automatic random_tick(int wild);
    tick_t t;
    int r;
    r = $urandom_range(99);
    if (r < 8) clock_ms += 32'($urandom_range(9));
    else if (r < 12) clock_ms += 32'($urandom);
    else clock_ms += 32'(10 + $urandom_range(wild));
    t.now = clock_ms;
    t.fire = ($urandom_range(19) == 0);
    t.running = ($urandom_range(29) != 0);
    if ($urandom_range(3) != 0) upd_count += 32'(1 + $urandom_range(3));
    if ($urandom_range(39) == 0) err_count += 32'd1;
    if ($urandom_range(99) == 0) upd_count = $urandom;
    t.upd = upd_count;
    t.err = err_count;
    t.ok = ($urandom_range(9) == 0) ? 3'($urandom) : 3'b111;
    for (int c = 0; c < 3; c++)
      case ($urandom_range(3))
        0: t.raw[c] = 12'($urandom_range(4095));
        1: t.raw[c] = ($urandom_range(1) != 0) ? 12'($urandom_range(20)) :
                                                 12'(4075 + $urandom_range(20));
        2: t.raw[c] = 12'd2048 + 12'($urandom_range(6));
        default: t.raw[c] = 12'($urandom_range(900));
      endcase
    send_tick(t);
  endtask

  task automatic short_timers(logic [31:0] rc, logic [31:0] sc, logic [31:0] bc);
    write_reg(acfm_pkg::REG_RAIL_CONF, rc);
    write_reg(acfm_pkg::REG_STUCK_CONF, sc);
    write_reg(acfm_pkg::REG_BIAS_CONF, bc);
  endtask

  initial begin
    tick_t t;
    quiet_cycles = 0;
    send_idle_pct = 13;
    recv_idle_pct = 67;
    clock_ms = 0; upd_count = 0; err_count = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: first tick, skipped tick, time zero, extremes, failed reads.
    t.fire = 0; t.running = 1; t.err = 0; t.ok = 3'b111;
    t.now = 0; t.upd = 0; t.raw = '{12'd0, 12'd4095, 12'd2048}; send_tick(t);
    t.now = 10; t.upd = 1; send_tick(t);
    t.now = 15; t.upd = 2; send_tick(t);
    t.now = 20; t.upd = 32'hFFFFFFFF; t.ok = 3'b000; send_tick(t);
    t.now = 30; t.ok = 3'b101; t.fire = 1; t.raw = '{12'hFFF, 12'h000, 12'hAAA}; send_tick(t);
    t.now = 32'hFFFFFFFF; t.err = 32'hFFFFFFFF; t.fire = 0; t.running = 0; t.ok = 3'b010;
    send_tick(t);
    t.now = 8; t.running = 1; t.ok = 3'b111; send_tick(t);
    t.now = 2000; t.upd = 5; t.raw = '{12'h555, 12'h2AA, 12'h7FF}; send_tick(t);
    clock_ms = 2000; upd_count = 5; err_count = 32'hFFFFFFFF;
    drain();
    write_reg(8'd9, 32'h1234);
    write_reg(acfm_pkg::REG_RAIL_LOW, 32'd100);
    write_reg(acfm_pkg::REG_RAIL_HIGH, 32'd4000);
    write_reg(acfm_pkg::REG_DEADBAND, 32'd0);
    short_timers(32'd0, 32'd0, 32'd0);
    for (int i = 0; i < 120; i++) random_tick(20);
    drain();

    // Pauses fall here: the sender waits for every result before config changes.
    write_reg(acfm_pkg::REG_BIAS_LOW, 32'd1500);
    write_reg(acfm_pkg::REG_BIAS_HIGH, 32'd1600);
    write_reg(acfm_pkg::REG_DEADBAND, 32'd255);
    short_timers(32'd50, 32'd300, 32'd40);
    for (int i = 0; i < 350; i++) random_tick(60);
    drain();

    send_idle_pct = 67;
    recv_idle_pct = 13;
    write_reg(acfm_pkg::REG_RAIL_LOW, 32'd0);
    write_reg(acfm_pkg::REG_RAIL_HIGH, 32'hFFF);
    write_reg(acfm_pkg::REG_BIAS_LOW, 32'd0);
    write_reg(acfm_pkg::REG_BIAS_HIGH, 32'hFFF);
    write_reg(acfm_pkg::REG_DEADBAND, 32'd20);
    short_timers(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    for (int i = 0; i < 250; i++) random_tick(40);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(acfm_pkg::REG_RAIL_LOW, 32'd16);
    write_reg(acfm_pkg::REG_RAIL_HIGH, 32'd4079);
    write_reg(acfm_pkg::REG_BIAS_LOW, 32'd1024);
    write_reg(acfm_pkg::REG_BIAS_HIGH, 32'd3071);
    write_reg(acfm_pkg::REG_DEADBAND, 32'd5);
    short_timers(32'd200, 32'd1000, 32'd100);
    for (int i = 0; i < 720; i++) random_tick(400);
    drain();
    repeat (10) @(posedge clk_i);

    if (monitor_model.errors == 0 && monitor_model.pending.size() == 0)
      $display("adc_chain_fault_monitor regression: pass");
    else
      $display("adc_chain_fault_monitor regression: fail");
    $finish;
  end
endmodule

// File: filelist.f
sv/acfm_pkg.sv
sv/acfm_lane.sv
sv/acfm_dma.sv
sv/adc_chain_fault_monitor.sv
sv/acfm_checker.sv
bench/adc_chain_fault_monitor_test.sv
